@@ hdl/lcd_pkg.sv @@
package lcd_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int THRESH_BITS     = 16;
	localparam int CODE_BITS       = 3;
	localparam int APB_DATA_BITS   = 32;
	localparam int APB_ADDR_BITS   = 3;

	localparam logic signed [THRESH_BITS-1:0] THRESH_RESET = 16'sd2048;

	typedef enum logic [CODE_BITS-1:0] {
		LC_NRZ   = 3'd0,
		LC_NRZI  = 3'd1,
		LC_MANCH = 3'd2,
		LC_DMANCH = 3'd3,
		LC_RZ    = 3'd4
	} line_code_t;

	typedef enum logic {
		REG_LINE_CODE = 1'b0,
		REG_THRESH    = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic bit_valid;
		logic bit_value;
		logic edge_seen;
	} lcd_result_t;

endpackage

@@ hdl/lcd_in_if.sv @@
interface lcd_in_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          block_start;

	modport source (output valid, output sample, output block_start, input ready);
	modport sink   (input valid, input sample, input block_start, output ready);
endinterface

@@ hdl/lcd_out_if.sv @@
interface lcd_out_if;
	logic valid;
	logic ready;
	logic bit_valid;
	logic bit_value;
	logic edge_seen;

	modport source (output valid, output bit_valid, output bit_value, output edge_seen,
		input ready);
	modport sink   (input valid, input bit_valid, input bit_value, input edge_seen,
		output ready);
endinterface

@@ hdl/lcd_core.sv @@
module lcd_core
	import lcd_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          block_start,
	input  logic [CODE_BITS-1:0]          line_code,
	input  logic signed [THRESH_BITS-1:0] slice_threshold,
	output lcd_result_t                   res
);

	localparam int CMP_BITS = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;

	logic                          prev_level_q;
	logic                          have_prev_q;
	logic                          pair_phase_q;
	logic                          prev_trans_q;
	logic signed [SAMPLE_BITS-1:0] held_q;

	logic                          pl, hp, ph, pt;
	logic signed [CMP_BITS-1:0]    sample_x, thresh_x;
	logic                          level, trans;
	logic                          pair_phase_d, prev_trans_d, hold_en;

	assign sample_x = CMP_BITS'(sample);
	assign thresh_x = CMP_BITS'(slice_threshold);

	// block start clears running state before this sample is used
	assign pl = block_start ? 1'b0 : prev_level_q;
	assign hp = block_start ? 1'b0 : have_prev_q;
	assign ph = block_start ? 1'b0 : pair_phase_q;
	assign pt = block_start ? 1'b0 : prev_trans_q;

	assign level = (sample_x >= thresh_x);
	assign trans = (held_q < sample);

	always_comb begin
		res.bit_valid = 1'b0;
		res.bit_value = 1'b0;
		res.edge_seen = hp & (level != pl);
		pair_phase_d  = ph;
		prev_trans_d  = pt;
		hold_en       = 1'b0;
		case (line_code)
			LC_NRZ, LC_RZ: begin
				res.bit_valid = 1'b1;
				res.bit_value = level;
			end
			LC_NRZI: begin
				res.bit_valid = 1'b1;
				res.bit_value = level ^ pl;
			end
			LC_MANCH, LC_DMANCH: begin
				if (!ph) begin
					hold_en      = 1'b1;
					pair_phase_d = 1'b1;
				end else begin
					pair_phase_d  = 1'b0;
					res.bit_valid = 1'b1;
					if (line_code == LC_MANCH) begin
						res.bit_value = trans;
					end else begin
						res.bit_value = trans ^ pt;
						prev_trans_d  = trans;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q <= 1'b0;
			have_prev_q  <= 1'b0;
			pair_phase_q <= 1'b0;
			prev_trans_q <= 1'b0;
		end else if (step) begin
			prev_level_q <= level;
			have_prev_q  <= 1'b1;
			pair_phase_q <= pair_phase_d;
			prev_trans_q <= prev_trans_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && hold_en) begin
			held_q <= sample;
		end
	end

endmodule

@@ hdl/line_code_decoder.sv @@
// Line decoder for NRZ, NRZI, Manchester, differential Manchester and RZ.
// Pipeline: an input register, then a result register loaded with the decode
// of the stage-1 sample, which uses the running decode state held in lcd_core.
// Throughput: one sample per cycle, sustained while the result side takes one.
// Reset (arst_n low, async): pipeline empty, decode state cleared,
// line_code = NRZ, slice_threshold = 0.5 (Q3.12).
module line_code_decoder
	import lcd_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready,
	lcd_in_if.sink                   sample_ch,
	lcd_out_if.source                res_ch
);

	logic [CODE_BITS-1:0]          line_code_q;
	logic signed [THRESH_BITS-1:0] thresh_q;
	reg_index_t                    reg_sel;

	logic                          valid_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic                          block_start_s1;

	logic                          out_valid_q;
	lcd_result_t                   result_q;
	lcd_result_t                   core_res;
	logic                          advance;

	// configuration
	assign pready  = 1'b1;
	assign reg_sel = reg_index_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_code_q <= CODE_BITS'(LC_NRZ);
			thresh_q    <= THRESH_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_sel)
				REG_LINE_CODE: line_code_q <= pwdata[CODE_BITS-1:0];
				REG_THRESH:    thresh_q    <= pwdata[THRESH_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_LINE_CODE: prdata = APB_DATA_BITS'(line_code_q);
			REG_THRESH:    prdata = APB_DATA_BITS'(thresh_q);
			default:       prdata = '0;
		endcase
	end

	// stage 1 moves into the result register when it is empty or being drained
	assign advance         = valid_s1 && (!out_valid_q || res_ch.ready);
	assign sample_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ch.valid && sample_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ch.valid && sample_ch.ready) begin
			sample_s1      <= sample_ch.sample;
			block_start_s1 <= sample_ch.block_start;
		end
	end

	lcd_core #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.sample         (sample_s1),
		.block_start    (block_start_s1),
		.line_code      (line_code_q),
		.slice_threshold(thresh_q),
		.res            (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (res_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= core_res;
		end
	end

	assign res_ch.valid     = out_valid_q;
	assign res_ch.bit_valid = result_q.bit_valid;
	assign res_ch.bit_value = result_q.bit_value;
	assign res_ch.edge_seen = result_q.edge_seen;

`ifndef SYNTHESIS
	a_advance_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("result register not loaded after stage 1 advanced");

	a_value_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result_q.bit_valid |-> !result_q.bit_value)
		else $error("bit_value set without bit_valid");

	a_s1_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(sample_s1) && $stable(block_start_s1))
		else $error("stage 1 lost or changed a stalled transaction");

	a_busy_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ch.ready |-> valid_s1 && out_valid_q && !res_ch.ready)
		else $error("input stalled while pipeline has room");
`endif

endmodule

@@ tb/line_code_decoder_tb.sv @@
`timescale 1ns / 100ps

module line_code_decoder_tb;
	import lcd_pkg::*;

	localparam int SB = SAMPLE_BITS_DEF;
	localparam logic signed [SB-1:0] S_MIN = 16'sh8000;
	localparam logic signed [SB-1:0] S_MAX = 16'sh7fff;
	// codes outside the defined set: decoder must give no bit
	localparam logic [CODE_BITS-1:0] UNUSED_LO = 3'd5;
	localparam logic [CODE_BITS-1:0] UNUSED_HI = 3'd7;
	localparam int N_PHASES = 13;
	localparam int PHASE_ITEMS = 55;

	typedef struct packed {
		logic [CODE_BITS-1:0]          code;
		logic signed [THRESH_BITS-1:0] thr;
		logic signed [SB-1:0]          smp;
		logic                          start;
		logic                          typed;
		lcd_result_t                   res;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_BITS-1:0] paddr;
	logic [APB_DATA_BITS-1:0] pwdata;
	logic [APB_DATA_BITS-1:0] prdata;
	logic pready;

	lcd_in_if #(.SAMPLE_BITS(SB)) sample_if ();
	lcd_out_if res_if ();

	line_code_decoder #(.SAMPLE_BITS(SB)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.sample_ch (sample_if),
		.res_ch    (res_if)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// decoder model state and its copy of the registers
	logic [CODE_BITS-1:0]          cfg_code = LC_NRZ;
	logic signed [THRESH_BITS-1:0] cfg_thr  = THRESH_RESET;
	logic                          lvl_prev = 1'b0;
	logic                          seen_sample = 1'b0;
	logic                          half_pending = 1'b0;
	logic signed [SB-1:0]          first_half = '0;
	logic                          trans_prev = 1'b0;

	lcd_result_t decodes_due [$];
	int bad_fields = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_bits = 0;
	bit idle_on = 1'b0;
	int stall_cnt = 0;

	dir_row_t dir_rows [0:24] = '{
		'{LC_NRZ, THRESH_RESET, THRESH_RESET, 1'b1, 1'b1, '{1'b1, 1'b1, 1'b0}},
		'{LC_NRZ, THRESH_RESET, 16'sd2047, 1'b0, 1'b1, '{1'b1, 1'b0, 1'b1}},
		'{LC_NRZ, THRESH_RESET, S_MAX, 1'b0, 1'b1, '{1'b1, 1'b1, 1'b1}},
		'{LC_NRZ, THRESH_RESET, S_MIN, 1'b0, 1'b1, '{1'b1, 1'b0, 1'b1}},
		'{LC_NRZ, S_MIN, S_MIN, 1'b1, 1'b1, '{1'b1, 1'b1, 1'b0}},
		'{LC_NRZ, S_MAX, S_MAX, 1'b1, 1'b1, '{1'b1, 1'b1, 1'b0}},
		'{LC_NRZ, S_MAX, 16'sd32766, 1'b0, 1'b1, '{1'b1, 1'b0, 1'b1}},
		'{LC_NRZI, 16'sd0, 16'sd100, 1'b1, 1'b0, '0},
		'{LC_NRZI, 16'sd0, 16'sd200, 1'b0, 1'b0, '0},
		'{LC_NRZI, 16'sd0, -16'sd1, 1'b0, 1'b0, '0},
		'{LC_RZ, 16'sd0, 16'sd0, 1'b1, 1'b0, '0},
		'{LC_RZ, 16'sd0, -16'sd1, 1'b0, 1'b0, '0},
		'{LC_MANCH, 16'sd0, -16'sd100, 1'b1, 1'b0, '0},
		'{LC_MANCH, 16'sd0, 16'sd100, 1'b0, 1'b0, '0},
		'{LC_MANCH, 16'sd0, 16'sd5, 1'b0, 1'b0, '0},
		'{LC_MANCH, 16'sd0, 16'sd5, 1'b0, 1'b0, '0},
		// odd trailing half, dropped by the next block start
		'{LC_MANCH, 16'sd0, 16'sd7, 1'b0, 1'b0, '0},
		'{LC_MANCH, 16'sd0, -16'sd7, 1'b1, 1'b0, '0},
		// code switch mid-pair: the held half carries over
		'{LC_DMANCH, 16'sd0, 16'sd9, 1'b0, 1'b0, '0},
		'{LC_DMANCH, 16'sd0, 16'sd10, 1'b0, 1'b0, '0},
		'{LC_DMANCH, 16'sd0, 16'sd20, 1'b0, 1'b0, '0},
		'{LC_DMANCH, 16'sd0, 16'sd30, 1'b0, 1'b0, '0},
		'{LC_DMANCH, 16'sd0, 16'sd25, 1'b0, 1'b0, '0},
		'{UNUSED_HI, 16'sd0, -16'sd5, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b1}},
		'{UNUSED_LO, 16'sd0, 16'sd5, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b1}}
	};

	logic [CODE_BITS-1:0] phase_codes [0:N_PHASES-1] = '{
		LC_NRZ, LC_NRZI, LC_MANCH, LC_DMANCH, LC_RZ, LC_MANCH, LC_DMANCH,
		LC_NRZI, UNUSED_LO, LC_NRZ, LC_DMANCH, LC_MANCH, UNUSED_HI
	};

	function automatic lcd_result_t decode_sample(input logic signed [SB-1:0] smp,
		input logic start);
		lcd_result_t r;
		logic lvl;
		logic t;
		if (start) begin
			lvl_prev = 1'b0;
			seen_sample = 1'b0;
			half_pending = 1'b0;
			trans_prev = 1'b0;
		end
		lvl = (smp >= cfg_thr);
		r = '0;
		r.edge_seen = seen_sample && (lvl != lvl_prev);
		case (cfg_code)
			LC_NRZ, LC_RZ: begin
				r.bit_valid = 1'b1;
				r.bit_value = lvl;
			end
			LC_NRZI: begin
				r.bit_valid = 1'b1;
				r.bit_value = lvl ^ lvl_prev;
			end
			LC_MANCH, LC_DMANCH: begin
				if (!half_pending) begin
					first_half = smp;
					half_pending = 1'b1;
				end else begin
					t = (first_half < smp);
					half_pending = 1'b0;
					r.bit_valid = 1'b1;
					if (cfg_code == LC_MANCH) begin
						r.bit_value = t;
					end else begin
						r.bit_value = t ^ trans_prev;
						trans_prev = t;
					end
				end
			end
			default: ;
		endcase
		lvl_prev = lvl;
		seen_sample = 1'b1;
		return r;
	endfunction

	function automatic int unsigned pick_gap();
		if ($urandom_range(0, 15) == 0)
			return $urandom_range(8, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic logic signed [SB-1:0] rand_sample();
		int v;
		case ($urandom_range(0, 5))
			0, 1: return SB'($urandom);
			2: begin
				case ($urandom_range(0, 3))
					0: return S_MIN;
					1: return S_MAX;
					2: return cfg_thr;
					default: return cfg_thr - 1'b1;
				endcase
			end
			default: begin
				v = int'(cfg_thr) + int'($urandom_range(0, 600)) - 300;
				if (v > 32767)
					v = 32767;
				if (v < -32768)
					v = -32768;
				return SB'(v);
			end
		endcase
	endfunction

	task automatic flag_mismatch(input string what, input logic got, input logic want);
		bad_fields++;
		if (bad_fields <= 20)
			$display("%0t: %s mismatch, got %b want %b (result %0d)", $realtime, what,
				got, want, n_checked);
	endtask

	// APB write: setup, then access until pready, then back to idle
	task automatic write_reg(input reg_index_t idx, input logic [APB_DATA_BITS-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (pready !== 1'b1);
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_LINE_CODE: cfg_code = data[CODE_BITS-1:0];
			REG_THRESH: cfg_thr = data[THRESH_BITS-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic send_sample(input logic signed [SB-1:0] smp, input logic start,
		input logic typed, input lcd_result_t typed_res);
		lcd_result_t pred;
		int unsigned gap;
		sample_if.valid <= 1'b1;
		sample_if.sample <= smp;
		sample_if.block_start <= start;
		do @(negedge clk); while (sample_if.ready !== 1'b1);
		pred = decode_sample(smp, start);
		decodes_due.push_back(typed ? typed_res : pred);
		n_sent++;
		@(posedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = pick_gap();
			sample_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// sender holds off until every decode has come back, plus pipeline latency
	task automatic wait_results_drained();
		sample_if.valid <= 1'b0;
		do @(posedge clk); while (decodes_due.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (stall_cnt != 0) begin
			res_if.ready <= 1'b0;
			stall_cnt--;
		end else if (idle_on && $urandom_range(0, 3) == 0) begin
			res_if.ready <= 1'b0;
			stall_cnt = pick_gap() - 1;
		end else begin
			res_if.ready <= 1'b1;
		end
	end

	// values are stable from negedge to the next rising edge, where the transaction lands
	always @(negedge clk) begin
		lcd_result_t want;
		if (arst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
			if (decodes_due.size() == 0) begin
				flag_mismatch("unexpected result", res_if.bit_valid, 1'bx);
			end else begin
				want = decodes_due.pop_front();
				if (res_if.bit_valid !== want.bit_valid)
					flag_mismatch("bit_valid", res_if.bit_valid, want.bit_valid);
				if (res_if.bit_value !== want.bit_value)
					flag_mismatch("bit_value", res_if.bit_value, want.bit_value);
				if (res_if.edge_seen !== want.edge_seen)
					flag_mismatch("edge_seen", res_if.edge_seen, want.edge_seen);
				if (want.bit_valid)
					n_bits++;
			end
			n_checked++;
		end
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		dir_row_t row;
		logic signed [THRESH_BITS-1:0] thr;
		logic st;
		int blen;
		int left;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sample_if.valid = 1'b0;
		sample_if.sample = '0;
		sample_if.block_start = 1'b0;
		res_if.ready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 25; i++) begin
			row = dir_rows[i];
			if (row.code !== cfg_code || row.thr !== cfg_thr) begin
				wait_results_drained();
				if (row.code !== cfg_code)
					write_reg(REG_LINE_CODE, APB_DATA_BITS'(row.code));
				if (row.thr !== cfg_thr)
					write_reg(REG_THRESH, {{16{row.thr[THRESH_BITS-1]}}, row.thr});
			end
			send_sample(row.smp, row.start, row.typed, row.res);
		end

		for (int ph = 0; ph < N_PHASES; ph++) begin
			wait_results_drained();
			idle_on = (ph % 4) != 3;
			if (ph == 0)
				thr = S_MIN;
			else if (ph == 1)
				thr = S_MAX;
			else if (ph == 2)
				thr = '0;
			else if ($urandom_range(0, 3) == 0)
				thr = THRESH_BITS'($urandom);
			else
				thr = THRESH_BITS'(int'($urandom_range(0, 16383)) - 8192);
			write_reg(REG_LINE_CODE, APB_DATA_BITS'(phase_codes[ph]));
			write_reg(REG_THRESH, {{16{thr[THRESH_BITS-1]}}, thr});
			left = PHASE_ITEMS;
			// first block of a phase may continue the previous one across the code change
			st = $urandom_range(0, 1);
			while (left > 0) begin
				blen = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) :
					$urandom_range(1, 12);
				for (int k = 0; k < blen && left > 0; k++) begin
					send_sample(rand_sample(), (k == 0) ? st : ($urandom_range(0, 39) == 0),
						1'b0, '0);
					left--;
				end
				st = 1'b1;
			end
		end

		wait_results_drained();
		$display("Decoded %0d samples into %0d results (%0d bits), %0d field mismatches.",
			n_sent, n_checked, n_bits, bad_fields);
		$display("Covered all five codes, unused codes, threshold extremes, stalls both sides.");
		if (bad_fields == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/lcd_pkg.sv
hdl/lcd_in_if.sv
hdl/lcd_out_if.sv
hdl/lcd_core.sv
hdl/line_code_decoder.sv
tb/line_code_decoder_tb.sv
